// File: hw/rtl/pca_pkg.sv
// ----------------------------------------------------------------------------
// pca_pkg: shared types and constants of the palette color allocator
// Holds the outcome codes, the search limit and the command and status
// words that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package pca_pkg;

  localparam int PALETTE_DEPTH_DEF = 256;
  localparam int CFG_W             = 9;
  localparam logic [CFG_W-1:0] COLORS_IN_USE_RST = 9'd256;

  // Squared distance of three 8-bit channels fits in 18 bits.
  localparam int DIST_W     = 18;
  localparam int NEAR_LIMIT = 10000;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_ADD   = 1'b1;

  localparam logic [1:0] OUT_WRITTEN = 2'd0;
  localparam logic [1:0] OUT_MATCH   = 2'd1;
  localparam logic [1:0] OUT_ALLOC   = 2'd2;
  localparam logic [1:0] OUT_NEAREST = 2'd3;

  typedef struct packed {
    logic       clr_wr;
    logic       load_in;
    logic       item_wr;
    logic       scan_init;
    logic       scan_step;
    logic       alloc_wr;
    logic       near_init;
    logic       near_step;
    logic       res_load;
    logic [1:0] res_outcome;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic match_hit;
    logic match_end;
    logic free_found;
    logic near_end;
    logic out_free;
  } status_t;

endpackage

// File: hw/rtl/pca_ram.sv
// ----------------------------------------------------------------------------
// pca_ram: generic single-write, single-read RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module pca_ram #(
  parameter int WIDTH = 25,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/pca_ctrl.sv
// ----------------------------------------------------------------------------
// pca_ctrl: sequencer of the palette color allocator
// Runs the clearing pass, then steps each word through a write, or through exact
// match, allocation and nearest search as needed, and hands the result to the output stage.
// ----------------------------------------------------------------------------
module pca_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_func,
  input  logic             in_nearest_only,
  output logic             in_stall,
  input  pca_pkg::status_t status,
  output pca_pkg::cmd_t    cmd
);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_WRITE = 4'd2;
  localparam logic [3:0] S_MINIT = 4'd3;
  localparam logic [3:0] S_MATCH = 4'd4;
  localparam logic [3:0] S_MEVAL = 4'd5;
  localparam logic [3:0] S_ALLOC = 4'd6;
  localparam logic [3:0] S_NINIT = 4'd7;
  localparam logic [3:0] S_NEAR  = 4'd8;
  localparam logic [3:0] S_NFIN  = 4'd9;
  localparam logic [3:0] S_DONE  = 4'd10;

  logic [3:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (status.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          if (in_func == pca_pkg::FUNC_WRITE) begin
            state_nxt = S_WRITE;
          end else if (in_nearest_only) begin
            state_nxt = S_NINIT;
          end else begin
            state_nxt = S_MINIT;
          end
        end
      end
      S_WRITE: begin
        cmd.item_wr     = 1'b1;
        cmd.res_load    = 1'b1;
        cmd.res_outcome = pca_pkg::OUT_WRITTEN;
        state_nxt       = S_DONE;
      end
      S_MINIT: begin
        cmd.scan_init = 1'b1;
        state_nxt     = S_MATCH;
      end
      S_MATCH: begin
        cmd.scan_step = 1'b1;
        if (status.match_hit) begin
          cmd.res_load    = 1'b1;
          cmd.res_outcome = pca_pkg::OUT_MATCH;
          state_nxt       = S_DONE;
        end else if (status.match_end) begin
          state_nxt = S_MEVAL;
        end
      end
      S_MEVAL: begin
        if (status.free_found) begin
          state_nxt = S_ALLOC;
        end else begin
          state_nxt = S_NINIT;
        end
      end
      S_ALLOC: begin
        cmd.alloc_wr    = 1'b1;
        cmd.res_load    = 1'b1;
        cmd.res_outcome = pca_pkg::OUT_ALLOC;
        state_nxt       = S_DONE;
      end
      S_NINIT: begin
        cmd.near_init = 1'b1;
        state_nxt     = S_NEAR;
      end
      S_NEAR: begin
        cmd.near_step = 1'b1;
        if (status.near_end) begin
          state_nxt = S_NFIN;
        end
      end
      S_NFIN: begin
        cmd.res_load    = 1'b1;
        cmd.res_outcome = pca_pkg::OUT_NEAREST;
        state_nxt       = S_DONE;
      end
      S_DONE: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// File: hw/rtl/pca_dp.sv
// ----------------------------------------------------------------------------
// pca_dp: datapath of the palette color allocator
// Palette memory, scan address counter, match and distance pipelines,
// result register and output register.
// ----------------------------------------------------------------------------
module pca_dp #(
  parameter int PALETTE_DEPTH = pca_pkg::PALETTE_DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  pca_pkg::cmd_t             cmd,
  output pca_pkg::status_t          status,
  input  logic [pca_pkg::CFG_W-1:0] colors_in_use,
  input  logic                      in_func,
  input  logic [7:0]                in_entry_index,
  input  logic [7:0]                in_red_level,
  input  logic [7:0]                in_green_level,
  input  logic [7:0]                in_blue_level,
  input  logic                      in_mark_used,
  input  logic                      in_nearest_only,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [7:0]                out_color_index,
  output logic [1:0]                out_outcome
);

  localparam int AW = $clog2(PALETTE_DEPTH);
  localparam int CW = $clog2(PALETTE_DEPTH + 1);
  localparam int NW = (CW > pca_pkg::CFG_W) ? CW : pca_pkg::CFG_W;
  localparam int LW = (CW > 8) ? CW : 8;
  localparam int DW = pca_pkg::DIST_W;

  // Item registers.
  logic       func_r;
  logic [7:0] idx_r, red_r, green_r, blue_r;
  logic       mark_r, nearest_r;

  // Scan and pipeline registers.
  logic [AW-1:0] clr_addr_r, scan_addr_r, s1_addr_r, s2_addr_r;
  logic [AW-1:0] free_addr_r, chosen_r, res_index_r;
  logic          iss_v_r, s1_v_r, s2_v_r, free_found_r;
  logic [15:0]   sq_r_r, sq_g_r, sq_b_r;
  logic [DW-1:0] best_r;
  logic [1:0]    res_outcome_r;
  logic          out_valid_r;
  logic [7:0]    out_index_r;
  logic [1:0]    out_outcome_r;

  // Active range clamped to 1..PALETTE_DEPTH.
  logic [NW-1:0] cfg_ext, n_eff, last_full;
  logic [AW-1:0] last_idx;

  always_comb begin
    cfg_ext = NW'(colors_in_use);
    n_eff   = cfg_ext;
    if (cfg_ext == '0) begin
      n_eff = NW'(1);
    end else if (cfg_ext > NW'(PALETTE_DEPTH)) begin
      n_eff = NW'(PALETTE_DEPTH);
    end
    last_full = n_eff - NW'(1);
  end
  assign last_idx = last_full[AW-1:0];

  // Palette memory: {used, red, green, blue}.
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [24:0]   ram_wdata, ram_rdata;
  logic          idx_ok;

  assign idx_ok = (LW'(idx_r) < LW'(PALETTE_DEPTH));

  always_comb begin
    ram_we    = cmd.clr_wr | (cmd.item_wr & idx_ok) | cmd.alloc_wr;
    ram_waddr = AW'(idx_r);
    ram_wdata = {mark_r, red_r, green_r, blue_r};
    if (cmd.clr_wr) begin
      ram_waddr = clr_addr_r;
      ram_wdata = '0;
    end else if (cmd.alloc_wr) begin
      ram_waddr = free_addr_r;
      ram_wdata = {1'b1, red_r, green_r, blue_r};
    end
  end

  pca_ram #(
    .WIDTH (25),
    .DEPTH (PALETTE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (scan_addr_r),
    .rdata (ram_rdata)
  );

  logic       rd_used;
  logic [7:0] rd_r, rd_g, rd_b, dr, dg, db;
  logic [DW-1:0] dist_sum;

  assign rd_used  = ram_rdata[24];
  assign rd_r     = ram_rdata[23:16];
  assign rd_g     = ram_rdata[15:8];
  assign rd_b     = ram_rdata[7:0];
  assign dr       = (rd_r > red_r)   ? (rd_r - red_r)   : (red_r - rd_r);
  assign dg       = (rd_g > green_r) ? (rd_g - green_r) : (green_r - rd_g);
  assign db       = (rd_b > blue_r)  ? (rd_b - blue_r)  : (blue_r - rd_b);
  assign dist_sum = DW'(sq_r_r) + DW'(sq_g_r) + DW'(sq_b_r);

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      func_r    <= in_func;
      idx_r     <= in_entry_index;
      red_r     <= in_red_level;
      green_r   <= in_green_level;
      blue_r    <= in_blue_level;
      mark_r    <= in_mark_used;
      nearest_r <= in_nearest_only;
    end
  end

  // Control flags of the scan pipeline and the output stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r   <= '0;
      iss_v_r      <= 1'b0;
      s1_v_r       <= 1'b0;
      s2_v_r       <= 1'b0;
      free_found_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cmd.clr_wr) begin
        clr_addr_r <= clr_addr_r + AW'(1);
      end
      if (cmd.scan_init || cmd.near_init) begin
        iss_v_r <= 1'b1;
        s1_v_r  <= 1'b0;
        s2_v_r  <= 1'b0;
      end else if (cmd.scan_step || cmd.near_step) begin
        if (cmd.scan_step && scan_addr_r == '0) begin
          iss_v_r <= 1'b0;
        end
        if (cmd.near_step && scan_addr_r == last_idx) begin
          iss_v_r <= 1'b0;
        end
        s1_v_r <= iss_v_r;
        s2_v_r <= s1_v_r & cmd.near_step;
      end
      if (cmd.scan_init) begin
        free_found_r <= 1'b0;
      end else if (cmd.scan_step && s1_v_r && !rd_used) begin
        free_found_r <= 1'b1;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Scan addresses, squares, best distance and result.
  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      scan_addr_r <= last_idx;
    end else if (cmd.near_init) begin
      scan_addr_r <= '0;
      best_r      <= DW'(pca_pkg::NEAR_LIMIT);
      chosen_r    <= '0;
    end else if (cmd.scan_step || cmd.near_step) begin
      if (iss_v_r) begin
        scan_addr_r <= cmd.scan_step ? scan_addr_r - AW'(1) : scan_addr_r + AW'(1);
      end
      s1_addr_r <= scan_addr_r;
      s2_addr_r <= s1_addr_r;
    end
    if (cmd.scan_step && s1_v_r && !rd_used) begin
      // Downward scan: the last unused entry seen is the lowest one.
      free_addr_r <= s1_addr_r;
    end
    if (cmd.near_step) begin
      sq_r_r <= 16'(dr) * 16'(dr);
      sq_g_r <= 16'(dg) * 16'(dg);
      sq_b_r <= 16'(db) * 16'(db);
      if (s2_v_r && dist_sum < best_r) begin
        best_r   <= dist_sum;
        chosen_r <= s2_addr_r;
      end
    end
    if (cmd.res_load) begin
      res_outcome_r <= cmd.res_outcome;
      case (cmd.res_outcome)
        pca_pkg::OUT_WRITTEN: res_index_r <= AW'(idx_r);
        pca_pkg::OUT_MATCH:   res_index_r <= s1_addr_r;
        pca_pkg::OUT_ALLOC:   res_index_r <= free_addr_r;
        default:              res_index_r <= chosen_r;
      endcase
    end
    if (cmd.out_load) begin
      // A write echoes the full entry index, even beyond the palette.
      out_index_r   <= (res_outcome_r == pca_pkg::OUT_WRITTEN) ? idx_r : 8'(res_index_r);
      out_outcome_r <= res_outcome_r;
    end
  end

  always_comb begin
    status.clr_last   = (clr_addr_r == AW'(PALETTE_DEPTH - 1));
    status.match_hit  = s1_v_r && rd_used && (rd_r == red_r) && (rd_g == green_r) &&
                        (rd_b == blue_r) && !nearest_r && func_r;
    status.match_end  = s1_v_r && (s1_addr_r == '0);
    status.free_found = free_found_r;
    status.near_end   = s2_v_r && (s2_addr_r == last_idx);
    status.out_free   = !out_valid_r || !out_stall;
  end

  assign out_valid       = out_valid_r;
  assign out_color_index = out_index_r;
  assign out_outcome     = out_outcome_r;

`ifndef SYNTHESIS
  a_alloc_needs_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.alloc_wr |-> free_found_r)
    else $error("allocation without a free entry");

  a_best_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.near_step && s2_v_r) |-> (best_r <= DW'(pca_pkg::NEAR_LIMIT)))
    else $error("best distance above the search limit");

  a_no_out_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || !out_stall))
    else $error("output register overwritten while held");

  a_hit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    status.match_hit |-> (s1_addr_r <= last_idx))
    else $error("match reported outside the active range");
`endif

endmodule

// File: hw/rtl/palette_color_allocator.sv
// Flow: a write word runs no scan; for an add-color word the exact-match scan and the nearest
// search run as needed over the palette memory port, one entry a cycle, over the N active
// entries, N being the active entry count.
// Throughput: one word in work at a time; the next is taken the cycle after the result
// loads into the output register, which waits while a held result is stalled.
// Reset: rst_n starts a clearing pass over every palette entry with no word taken; colors_in_use = 256.
// ----------------------------------------------------------------------------
// palette_color_allocator: palette store with exact match, allocation and
// nearest color search
// A controller sequences a datapath that holds the palette in a RAM, scans
// it one entry per cycle and reports the chosen entry and how it was found.
// ----------------------------------------------------------------------------
module palette_color_allocator #(
  parameter int PALETTE_DEPTH = pca_pkg::PALETTE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel.
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_func,
  input  logic [7:0]  in_entry_index,
  input  logic [7:0]  in_red_level,
  input  logic [7:0]  in_green_level,
  input  logic [7:0]  in_blue_level,
  input  logic        in_mark_used,
  input  logic        in_nearest_only,
  // Result channel.
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_color_index,
  output logic [1:0]  out_outcome,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // The only register, colors_in_use, sits at byte address 0. Address bit 2
  // selects it; the register space above it reads as zero and ignores writes.
  logic [pca_pkg::CFG_W-1:0] colors_in_use_r;
  logic                      cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      colors_in_use_r <= pca_pkg::COLORS_IN_USE_RST;
    end else if (cfg_wr) begin
      colors_in_use_r <= pwdata[pca_pkg::CFG_W-1:0];
    end
  end

  assign prdata = (paddr[2] == 1'b0) ? 32'(colors_in_use_r) : 32'd0;

  // The controller decides what happens in each cycle; the datapath reports
  // back when the clearing pass, a scan or the output stage is done.
  pca_pkg::cmd_t    cmd;
  pca_pkg::status_t status;

  pca_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_func         (in_func),
    .in_nearest_only (in_nearest_only),
    .in_stall        (in_stall),
    .status          (status),
    .cmd             (cmd)
  );

  pca_dp #(
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .colors_in_use   (colors_in_use_r),
    .in_func         (in_func),
    .in_entry_index  (in_entry_index),
    .in_red_level    (in_red_level),
    .in_green_level  (in_green_level),
    .in_blue_level   (in_blue_level),
    .in_mark_used    (in_mark_used),
    .in_nearest_only (in_nearest_only),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_color_index (out_color_index),
    .out_outcome     (out_outcome)
  );

endmodule
